>>> design/aes_pkg.sv
`default_nettype none
package aes_pkg;

   localparam int MaxRoundsDefault = 14;
   localparam int KeyRegCount = 4;

   localparam logic [2:0] CsrKey0 = 3'd0;
   localparam logic [2:0] CsrKey1 = 3'd1;
   localparam logic [2:0] CsrKey2 = 3'd2;
   localparam logic [2:0] CsrKey3 = 3'd3;
   localparam logic [2:0] CsrMode = 3'd4;

   localparam logic [1:0] Mode128 = 2'd0;
   localparam logic [1:0] Mode192 = 2'd1;

   typedef logic [7:0] byte_type;

   function automatic byte_type sbox(input byte_type x);
      byte_type s;
      s = 8'h00;
      case (x)
         8'h00: s = 8'h63; 8'h01: s = 8'h7c; 8'h02: s = 8'h77; 8'h03: s = 8'h7b;
         8'h04: s = 8'hf2; 8'h05: s = 8'h6b; 8'h06: s = 8'h6f; 8'h07: s = 8'hc5;
         8'h08: s = 8'h30; 8'h09: s = 8'h01; 8'h0a: s = 8'h67; 8'h0b: s = 8'h2b;
         8'h0c: s = 8'hfe; 8'h0d: s = 8'hd7; 8'h0e: s = 8'hab; 8'h0f: s = 8'h76;
         8'h10: s = 8'hca; 8'h11: s = 8'h82; 8'h12: s = 8'hc9; 8'h13: s = 8'h7d;
         8'h14: s = 8'hfa; 8'h15: s = 8'h59; 8'h16: s = 8'h47; 8'h17: s = 8'hf0;
         8'h18: s = 8'had; 8'h19: s = 8'hd4; 8'h1a: s = 8'ha2; 8'h1b: s = 8'haf;
         8'h1c: s = 8'h9c; 8'h1d: s = 8'ha4; 8'h1e: s = 8'h72; 8'h1f: s = 8'hc0;
         8'h20: s = 8'hb7; 8'h21: s = 8'hfd; 8'h22: s = 8'h93; 8'h23: s = 8'h26;
         8'h24: s = 8'h36; 8'h25: s = 8'h3f; 8'h26: s = 8'hf7; 8'h27: s = 8'hcc;
         8'h28: s = 8'h34; 8'h29: s = 8'ha5; 8'h2a: s = 8'he5; 8'h2b: s = 8'hf1;
         8'h2c: s = 8'h71; 8'h2d: s = 8'hd8; 8'h2e: s = 8'h31; 8'h2f: s = 8'h15;
         8'h30: s = 8'h04; 8'h31: s = 8'hc7; 8'h32: s = 8'h23; 8'h33: s = 8'hc3;
         8'h34: s = 8'h18; 8'h35: s = 8'h96; 8'h36: s = 8'h05; 8'h37: s = 8'h9a;
         8'h38: s = 8'h07; 8'h39: s = 8'h12; 8'h3a: s = 8'h80; 8'h3b: s = 8'he2;
         8'h3c: s = 8'heb; 8'h3d: s = 8'h27; 8'h3e: s = 8'hb2; 8'h3f: s = 8'h75;
         8'h40: s = 8'h09; 8'h41: s = 8'h83; 8'h42: s = 8'h2c; 8'h43: s = 8'h1a;
         8'h44: s = 8'h1b; 8'h45: s = 8'h6e; 8'h46: s = 8'h5a; 8'h47: s = 8'ha0;
         8'h48: s = 8'h52; 8'h49: s = 8'h3b; 8'h4a: s = 8'hd6; 8'h4b: s = 8'hb3;
         8'h4c: s = 8'h29; 8'h4d: s = 8'he3; 8'h4e: s = 8'h2f; 8'h4f: s = 8'h84;
         8'h50: s = 8'h53; 8'h51: s = 8'hd1; 8'h52: s = 8'h00; 8'h53: s = 8'hed;
         8'h54: s = 8'h20; 8'h55: s = 8'hfc; 8'h56: s = 8'hb1; 8'h57: s = 8'h5b;
         8'h58: s = 8'h6a; 8'h59: s = 8'hcb; 8'h5a: s = 8'hbe; 8'h5b: s = 8'h39;
         8'h5c: s = 8'h4a; 8'h5d: s = 8'h4c; 8'h5e: s = 8'h58; 8'h5f: s = 8'hcf;
         8'h60: s = 8'hd0; 8'h61: s = 8'hef; 8'h62: s = 8'haa; 8'h63: s = 8'hfb;
         8'h64: s = 8'h43; 8'h65: s = 8'h4d; 8'h66: s = 8'h33; 8'h67: s = 8'h85;
         8'h68: s = 8'h45; 8'h69: s = 8'hf9; 8'h6a: s = 8'h02; 8'h6b: s = 8'h7f;
         8'h6c: s = 8'h50; 8'h6d: s = 8'h3c; 8'h6e: s = 8'h9f; 8'h6f: s = 8'ha8;
         8'h70: s = 8'h51; 8'h71: s = 8'ha3; 8'h72: s = 8'h40; 8'h73: s = 8'h8f;
         8'h74: s = 8'h92; 8'h75: s = 8'h9d; 8'h76: s = 8'h38; 8'h77: s = 8'hf5;
         8'h78: s = 8'hbc; 8'h79: s = 8'hb6; 8'h7a: s = 8'hda; 8'h7b: s = 8'h21;
         8'h7c: s = 8'h10; 8'h7d: s = 8'hff; 8'h7e: s = 8'hf3; 8'h7f: s = 8'hd2;
         8'h80: s = 8'hcd; 8'h81: s = 8'h0c; 8'h82: s = 8'h13; 8'h83: s = 8'hec;
         8'h84: s = 8'h5f; 8'h85: s = 8'h97; 8'h86: s = 8'h44; 8'h87: s = 8'h17;
         8'h88: s = 8'hc4; 8'h89: s = 8'ha7; 8'h8a: s = 8'h7e; 8'h8b: s = 8'h3d;
         8'h8c: s = 8'h64; 8'h8d: s = 8'h5d; 8'h8e: s = 8'h19; 8'h8f: s = 8'h73;
         8'h90: s = 8'h60; 8'h91: s = 8'h81; 8'h92: s = 8'h4f; 8'h93: s = 8'hdc;
         8'h94: s = 8'h22; 8'h95: s = 8'h2a; 8'h96: s = 8'h90; 8'h97: s = 8'h88;
         8'h98: s = 8'h46; 8'h99: s = 8'hee; 8'h9a: s = 8'hb8; 8'h9b: s = 8'h14;
         8'h9c: s = 8'hde; 8'h9d: s = 8'h5e; 8'h9e: s = 8'h0b; 8'h9f: s = 8'hdb;
         8'ha0: s = 8'he0; 8'ha1: s = 8'h32; 8'ha2: s = 8'h3a; 8'ha3: s = 8'h0a;
         8'ha4: s = 8'h49; 8'ha5: s = 8'h06; 8'ha6: s = 8'h24; 8'ha7: s = 8'h5c;
         8'ha8: s = 8'hc2; 8'ha9: s = 8'hd3; 8'haa: s = 8'hac; 8'hab: s = 8'h62;
         8'hac: s = 8'h91; 8'had: s = 8'h95; 8'hae: s = 8'he4; 8'haf: s = 8'h79;
         8'hb0: s = 8'he7; 8'hb1: s = 8'hc8; 8'hb2: s = 8'h37; 8'hb3: s = 8'h6d;
         8'hb4: s = 8'h8d; 8'hb5: s = 8'hd5; 8'hb6: s = 8'h4e; 8'hb7: s = 8'ha9;
         8'hb8: s = 8'h6c; 8'hb9: s = 8'h56; 8'hba: s = 8'hf4; 8'hbb: s = 8'hea;
         8'hbc: s = 8'h65; 8'hbd: s = 8'h7a; 8'hbe: s = 8'hae; 8'hbf: s = 8'h08;
         8'hc0: s = 8'hba; 8'hc1: s = 8'h78; 8'hc2: s = 8'h25; 8'hc3: s = 8'h2e;
         8'hc4: s = 8'h1c; 8'hc5: s = 8'ha6; 8'hc6: s = 8'hb4; 8'hc7: s = 8'hc6;
         8'hc8: s = 8'he8; 8'hc9: s = 8'hdd; 8'hca: s = 8'h74; 8'hcb: s = 8'h1f;
         8'hcc: s = 8'h4b; 8'hcd: s = 8'hbd; 8'hce: s = 8'h8b; 8'hcf: s = 8'h8a;
         8'hd0: s = 8'h70; 8'hd1: s = 8'h3e; 8'hd2: s = 8'hb5; 8'hd3: s = 8'h66;
         8'hd4: s = 8'h48; 8'hd5: s = 8'h03; 8'hd6: s = 8'hf6; 8'hd7: s = 8'h0e;
         8'hd8: s = 8'h61; 8'hd9: s = 8'h35; 8'hda: s = 8'h57; 8'hdb: s = 8'hb9;
         8'hdc: s = 8'h86; 8'hdd: s = 8'hc1; 8'hde: s = 8'h1d; 8'hdf: s = 8'h9e;
         8'he0: s = 8'he1; 8'he1: s = 8'hf8; 8'he2: s = 8'h98; 8'he3: s = 8'h11;
         8'he4: s = 8'h69; 8'he5: s = 8'hd9; 8'he6: s = 8'h8e; 8'he7: s = 8'h94;
         8'he8: s = 8'h9b; 8'he9: s = 8'h1e; 8'hea: s = 8'h87; 8'heb: s = 8'he9;
         8'hec: s = 8'hce; 8'hed: s = 8'h55; 8'hee: s = 8'h28; 8'hef: s = 8'hdf;
         8'hf0: s = 8'h8c; 8'hf1: s = 8'ha1; 8'hf2: s = 8'h89; 8'hf3: s = 8'h0d;
         8'hf4: s = 8'hbf; 8'hf5: s = 8'he6; 8'hf6: s = 8'h42; 8'hf7: s = 8'h68;
         8'hf8: s = 8'h41; 8'hf9: s = 8'h99; 8'hfa: s = 8'h2d; 8'hfb: s = 8'h0f;
         8'hfc: s = 8'hb0; 8'hfd: s = 8'h54; 8'hfe: s = 8'hbb; 8'hff: s = 8'h16;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   function automatic byte_type rcon(input logic [3:0] i);
      byte_type r;
      r = 8'h00;
      case (i)
         4'd0: r = 8'h8d; 4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04;
         4'd4: r = 8'h08; 4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40;
         4'd8: r = 8'h80; 4'd9: r = 8'h1b; 4'd10: r = 8'h36; 4'd11: r = 8'h6c;
         4'd12: r = 8'hd8; 4'd13: r = 8'hab; 4'd14: r = 8'h4d; 4'd15: r = 8'h9a;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic byte_type xtime(input byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte 0 of the block sits in bits 127:120
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (r + 4 * c) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] t;
      byte_type a0, a1, a2, a3, al;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
         t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

endpackage
`default_nettype wire

>>> design/aes_stream_if.sv
`default_nettype none
interface aes_stream_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_high;
   logic [63:0] data_low;
   modport source (output valid, output data_high, output data_low, input ready);
   modport sink (input valid, input data_high, input data_low, output ready);
endinterface
`default_nettype wire

>>> design/aes_key_expand.sv
`default_nettype none
// Key schedule: one word per cycle into a word-wide store; every round key is
// presented at once, each stage taking its own round.
module aes_key_expand #(
   parameter int MaxRounds = aes_pkg::MaxRoundsDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [255:0]  key,
   input  wire logic [1:0]    mode,
   output logic               busy,
   output logic [127:0]       round_key [MaxRounds+1]
);
   import aes_pkg::*;

   localparam int StoreWords = 4 * (MaxRounds + 1);
   localparam int IdxW = $clog2(StoreWords + 1);
   localparam int RndW = $clog2(MaxRounds + 1);

   logic [3:0] nk;
   logic [4:0] nr;
   logic [IdxW-1:0] total;
   always_comb begin
      nk = (mode == Mode128) ? 4'd4 : (mode == Mode192) ? 4'd6 : 4'd8;
      nr = 5'(nk) + 5'd6;
      if (int'(nr) > MaxRounds) nr = 5'(MaxRounds);
      total = IdxW'(4 * (int'(nr) + 1));
   end

   // four banks, one per column, each holding one word per round
   logic [31:0] bank0 [MaxRounds+1];
   logic [31:0] bank1 [MaxRounds+1];
   logic [31:0] bank2 [MaxRounds+1];
   logic [31:0] bank3 [MaxRounds+1];

   // last eight words produced, newest in slot 0
   logic [31:0] hist_ff [8];
   logic [31:0] hist_in [8];
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [3:0] mod_ff, mod_in;
   logic [3:0] quot_ff, quot_in;
   logic busy_ff, busy_in;
   logic [31:0] word, t, back;

   always_comb begin
      busy_in = busy_ff;
      idx_in = idx_ff;
      mod_in = mod_ff;
      quot_in = quot_ff;
      hist_in = hist_ff;
      t = hist_ff[0];
      back = hist_ff[nk[3:1] == 3'd2 ? 3'd3 : nk[3:1] == 3'd3 ? 3'd5 : 3'd7];
      word = '0;
      if (idx_ff < IdxW'(nk)) begin
         word = key[255 - 32 * idx_ff[2:0] -: 32];
      end else begin
         if (mod_ff == 4'd0) begin
            t = sub_word({hist_ff[0][23:0], hist_ff[0][31:24]}) ^ {rcon(quot_ff), 24'h0};
         end else if (nk == 4'd8 && mod_ff == 4'd4) begin
            t = sub_word(hist_ff[0]);
         end
         word = back ^ t;
      end
      if (start) begin
         busy_in = 1'b1;
         idx_in = '0;
         mod_in = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         hist_in[0] = word;
         for (int i = 1; i < 8; i++) hist_in[i] = hist_ff[i-1];
         idx_in = idx_ff + 1'b1;
         if (mod_ff == nk - 4'd1) begin
            mod_in = '0;
            quot_in = quot_ff + 4'd1;
         end else begin
            mod_in = mod_ff + 4'd1;
         end
         if (idx_ff == total - 1'b1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
         mod_ff <= '0;
         quot_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
         mod_ff <= mod_in;
         quot_ff <= quot_in;
      end
      hist_ff <= hist_in;
   end

   logic [RndW-1:0] wr_round;
   assign wr_round = RndW'(idx_ff >> 2);

   always_ff @(posedge clock) begin
      if (busy_ff && !start) begin
         case (idx_ff[1:0])
            2'd0: bank0[wr_round] <= word;
            2'd1: bank1[wr_round] <= word;
            2'd2: bank2[wr_round] <= word;
            default: bank3[wr_round] <= word;
         endcase
      end
   end

   always_comb begin
      for (int r = 0; r <= MaxRounds; r++)
         round_key[r] = {bank0[r], bank1[r], bank2[r], bank3[r]};
   end

   assign busy = busy_ff;

   mod_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> mod_ff < nk) else $error("key word position out of range");
   idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff < total) else $error("key word index past schedule");
   start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("expansion did not start");

endmodule
`default_nettype wire

>>> design/aes_block_encrypt_top.sv
`default_nettype none
// AES block encryption, 128/192/256-bit keys.
// Channels: req (plaintext item, plain_high/plain_low on data_high/data_low)
// and rsp (ciphertext item), both valid/ready; an item moves when both are high.
// csr_we/csr_index/csr_data write the key registers (0..3) and key length (4).
// Each write to index 0..4 restarts key expansion: one schedule word per cycle,
// 44, 52 or 60 words; req is held off (ready low) until the schedule is complete.
// Pipeline: one pipeline stage per round plus an input stage, i.e. MaxRounds+1
// register stages (15 at default); items of shorter keys take the last-round
// path at their own round count, then pass unchanged through the later stages.
// Throughput: one item per cycle unless rsp stalls or the schedule is busy, the
// pipeline being fully unrolled; the key store is read by fixed round per stage.
// Reset clears all valid bits and key registers; the store needs a write.
// If rsp stalls a valid result the pipeline holds; nothing is lost or repeated.
module aes_block_encrypt_top #(
   parameter int MaxRounds = aes_pkg::MaxRoundsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   aes_stream_if.sink       req,
   aes_stream_if.source     rsp,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import aes_pkg::*;

   localparam int Stages = MaxRounds + 1;

   logic [63:0] key_ff [KeyRegCount];
   logic [1:0]  mode_ff;
   logic        start;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KeyRegCount; i++) key_ff[i] <= '0;
         mode_ff <= Mode128;
      end else if (csr_we) begin
         case (csr_index)
            CsrKey0: key_ff[0] <= csr_data;
            CsrKey1: key_ff[1] <= csr_data;
            CsrKey2: key_ff[2] <= csr_data;
            CsrKey3: key_ff[3] <= csr_data;
            CsrMode: mode_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   assign start = csr_we && (csr_index <= CsrMode);

   logic        busy;
   logic [4:0]  nr;
   always_comb begin
      nr = (mode_ff == Mode128) ? 5'd10 : (mode_ff == Mode192) ? 5'd12 : 5'd14;
      if (int'(nr) > MaxRounds) nr = 5'(MaxRounds);
   end

   // round keys: each stage takes its own round from the schedule
   logic [127:0] rk [Stages];
   aes_key_expand #(.MaxRounds(MaxRounds)) u_keys (
      .clock(clock), .reset(reset), .start(start),
      .key({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}), .mode(mode_ff),
      .busy(busy), .round_key(rk)
   );

   logic         adv;
   logic         vld_ff [Stages];
   logic [127:0] st_ff [Stages];
   logic [127:0] st_in [Stages];

   assign adv = rsp.ready || !vld_ff[Stages-1];
   assign req.ready = adv && !busy && !start;

   always_comb begin
      logic [127:0] s;
      st_in[0] = {req.data_high, req.data_low} ^ rk[0];
      for (int g = 1; g < Stages; g++) begin
         s = sub_shift(st_ff[g-1]);
         if (g < int'(nr)) st_in[g] = mix_columns(s) ^ rk[g];
         else if (g == int'(nr)) st_in[g] = s ^ rk[g];
         else st_in[g] = st_ff[g-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < Stages; g++) vld_ff[g] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req.valid && req.ready;
         for (int g = 1; g < Stages; g++) vld_ff[g] <= vld_ff[g-1];
      end
      if (adv) begin
         for (int g = 0; g < Stages; g++) st_ff[g] <= st_in[g];
      end
   end

   assign rsp.valid = vld_ff[Stages-1];
   assign rsp.data_high = st_ff[Stages-1][127:64];
   assign rsp.data_low = st_ff[Stages-1][63:0];

   hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data_high))
      else $error("stalled result changed");
   no_take_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req.ready) else $error("item taken during key expansion");
   stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff[0] == $past(vld_ff[0])) else $error("pipeline moved in stall");

endmodule
`default_nettype wire

>>> tb/sv/aes_block_encrypt_top_tb.sv
module aes_block_encrypt_top_tb;
   import aes_pkg::*;

   localparam int StoreWords = 4 * (MaxRoundsDefault + 1);
   localparam logic [1:0] Mode256 = 2'd2;
   localparam logic [1:0] ModeSat = 2'd3;   // saturates to 256-bit
   localparam logic [2:0] CsrSpare = 3'd7;  // beyond the register list
   localparam int CycleLimit = 1500000;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } block_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   aes_stream_if req ();
   aes_stream_if rsp ();

   aes_block_encrypt_top u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state: key registers, mode and expanded schedule
   logic [63:0] key_reg [KeyRegCount];
   logic [1:0]  key_mode;
   logic [31:0] sched [StoreWords];

   block_type cipher_q [$];
   int     errors = 0;
   int     cycles = 0;
   bit     idle_on = 1'b1;

   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("%0t timeout", $time);
         $display("aes_block_encrypt_top_tb NOT OK");
         $finish;
      end
   end

   function automatic int nk_of(logic [1:0] m);
      if (m == Mode128) return 4;
      if (m == Mode192) return 6;
      return 8;
   endfunction

   function automatic logic [7:0] sb(logic [7:0] x);
      // S-box computed from the field inverse and the affine map
      logic [7:0] inv, p, a, r;
      inv = 8'h00;
      for (int i = 1; i < 256; i++) begin
         p = 8'h00; a = x;
         for (int b = 0; b < 8; b++) begin
            if (i[b]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         end
         if (p == 8'h01 && x != 8'h00) inv = i[7:0];
      end
      r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      return r;
   endfunction

   logic [7:0] sb_tab [256];
   initial for (int i = 0; i < 256; i++) sb_tab[i] = sb(i[7:0]);

   function automatic logic [7:0] dbl(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] subw(logic [31:0] w);
      return {sb_tab[w[31:24]], sb_tab[w[23:16]], sb_tab[w[15:8]], sb_tab[w[7:0]]};
   endfunction

   task automatic expand_schedule();
      int nk, total;
      logic [31:0] t;
      logic [7:0] rc;
      nk = nk_of(key_mode);
      total = 4 * (nk + 7);
      for (int i = 0; i < nk; i++)
         sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
      rc = 8'h01;
      for (int i = nk; i < total; i++) begin
         t = sched[i - 1];
         if (i % nk == 0) begin
            t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = dbl(rc);
         end else if (nk > 6 && i % nk == 4) begin
            t = subw(t);
         end
         sched[i] = sched[i - nk] ^ t;
      end
   endtask

   function automatic block_type encrypt_block(block_type pt);
      logic [7:0] s [16], t [16], a0, a1, a2, a3, al;
      int nr;
      block_type ct;
      nr = nk_of(key_mode) + 6;
      for (int b = 0; b < 16; b++) s[b] = pt[127 - 8 * b -: 8];
      for (int r = 0; r <= nr; r++) begin
         if (r > 0) begin
            for (int c = 0; c < 4; c++)
               for (int w = 0; w < 4; w++)
                  t[w + 4 * c] = sb_tab[s[w + 4 * ((c + w) % 4)]];
            s = t;
            if (r < nr) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                  al = a0 ^ a1 ^ a2 ^ a3;
                  s[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
                  s[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
                  s[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
                  s[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
               end
            end
         end
         for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
               s[4 * c + j] ^= sched[4 * r + c][31 - 8 * j -: 8];
      end
      for (int b = 0; b < 16; b++) ct[127 - 8 * b -: 8] = s[b];
      return ct;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // a gap drops valid for its length; otherwise valid stays high
   task automatic idle_burst();
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // block must be drained before this is called
   task automatic csr_write(logic [2:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx < 3'(KeyRegCount)) key_reg[idx] = val;
      else if (idx == CsrMode) key_mode = (val[1:0] == ModeSat) ? Mode256 : val[1:0];
      if (idx <= CsrMode) expand_schedule();
   endtask

   task automatic load_key(logic [1:0] m, logic [63:0] k0, logic [63:0] k1,
                           logic [63:0] k2, logic [63:0] k3);
      csr_write(CsrKey0, k0);
      csr_write(CsrKey1, k1);
      csr_write(CsrKey2, k2);
      csr_write(CsrKey3, k3);
      csr_write(CsrMode, {62'd0, m});
   endtask

   task automatic send_block(logic [63:0] hi, logic [63:0] lo);
      block_type pt;
      idle_burst();
      pt.hi = hi; pt.lo = lo;
      req.valid <= 1'b1;
      req.data_high <= hi;
      req.data_low <= lo;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      cipher_q.push_back(encrypt_block(pt));
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // result checker and receiver stalls
   initial begin
      int stall;
      block_type exp_ct;
      rsp.ready = 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            if (cipher_q.size() == 0) begin
               $display("%0t unexpected item hi=%h lo=%h", $time, rsp.data_high,
                        rsp.data_low);
               errors++;
            end else begin
               exp_ct = cipher_q.pop_front();
               if (rsp.data_high !== exp_ct.hi) begin
                  $display("%0t cipher_high exp %h got %h", $time, exp_ct.hi,
                           rsp.data_high);
                  errors++;
               end
               if (rsp.data_low !== exp_ct.lo) begin
                  $display("%0t cipher_low exp %h got %h", $time, exp_ct.lo,
                           rsp.data_low);
                  errors++;
               end
            end
         end
         if (stall > 0) stall--;
         else if (idle_on && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 17);
         rsp.ready <= (stall == 0);
      end
   end

   task automatic test_fips_vectors();
      // standard vectors for each key length
      load_key(Mode128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      drain();
      load_key(Mode192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
               64'h1011121314151617, '0);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      drain();
      csr_write(CsrKey3, 64'h18191a1b1c1d1e1f);
      csr_write(CsrMode, {62'd0, Mode256});
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      drain();
   endtask

   task automatic test_extremes();
      load_key(Mode128, '0, '0, '0, '0);
      send_block('0, '0);
      send_block('1, '1);
      drain();
      load_key(Mode256, '1, '1, '1, '1);
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      drain();
      // unknown register index leaves the key untouched
      csr_write(CsrSpare, '1);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
      drain();
   endtask

   task automatic test_mode_saturate();
      load_key(ModeSat, rand64(), rand64(), rand64(), rand64());
      repeat (4) send_block(rand64(), rand64());
      drain();
   endtask

   task automatic test_random(int n);
      logic [1:0] m;
      for (int i = 0; i < n; i++) begin
         if (i % 150 == 0) begin
            drain();
            m = 2'($urandom_range(0, 3));
            load_key(m, rand64(), rand64(), rand64(), rand64());
         end
         if (i == n / 2) drain();  // hold off until everything is back
         if (i >= n - 100) idle_on = 1'b0;
         send_block(rand64(), rand64());
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.data_high = '0;
      req.data_low = '0;
      for (int i = 0; i < KeyRegCount; i++) key_reg[i] = '0;
      key_mode = Mode128;
      for (int i = 0; i < StoreWords; i++) sched[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_fips_vectors();
      test_extremes();
      test_mode_saturate();
      test_random(1040);
      drain();
      if (errors == 0)
         $display("aes_block_encrypt_top_tb OK");
      else
         $display("aes_block_encrypt_top_tb NOT OK");
      $finish;
   end
endmodule
